[hw/rtl/bmwlp_pkg.sv]
// Types, constants and wave tables for the button mode / wave LED pattern block.
// No dependencies; used by the top level and the testbench.
package bmwlp_pkg;

  // Command codes on the request channel
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_PIN     = 3'd1;
  localparam logic [2:0] CMD_RESTORE = 3'd2;
  localparam logic [2:0] CMD_FRAME   = 3'd3;
  localparam logic [2:0] CMD_PIXEL   = 3'd4;

  // Result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  // Configuration register map (byte addresses)
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_LONG_PRESS  = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SHORT_PRESS = 3'd4;
  localparam logic [7:0] LONG_PRESS_RESET  = 8'd50;
  localparam logic [7:0] SHORT_PRESS_RESET = 8'd3;

  // Pattern geometry
  localparam int unsigned WAVE_STEPS = 24;
  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned SAVE_CELLS = 64;
  localparam int unsigned MODE_TOTAL = 9;
  localparam logic [7:0] EMPTY_CELL  = 8'hFF;
  localparam logic [7:0] TICK_MAX    = 8'hFF;

  // Reciprocal for the phase wrap: q = (sum * WAVE_RECIP) >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned WAVE_RECIP  = ((1 << RECIP_SHIFT) + WAVE_STEPS - 1) / WAVE_STEPS;

  // Colour channel codes
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } chan_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] store_address;
    logic [7:0] store_data;
    logic       last;
  } result_t;

  function automatic logic [7:0] hard_wave(input logic [4:0] pos);
    logic [7:0] v;
    case (pos)
      5'd0:  v = 8'd0;   5'd1:  v = 8'd5;   5'd2:  v = 8'd15;  5'd3:  v = 8'd30;
      5'd4:  v = 8'd60;  5'd5:  v = 8'd100; 5'd6:  v = 8'd150; 5'd7:  v = 8'd200;
      5'd8:  v = 8'd240; 5'd9:  v = 8'd255; 5'd10: v = 8'd255; 5'd11: v = 8'd240;
      5'd12: v = 8'd220; 5'd13: v = 8'd200; 5'd14: v = 8'd170; 5'd15: v = 8'd140;
      5'd16: v = 8'd110; 5'd17: v = 8'd80;  5'd18: v = 8'd55;  5'd19: v = 8'd35;
      5'd20: v = 8'd20;  5'd21: v = 8'd10;  5'd22: v = 8'd5;   5'd23: v = 8'd0;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] soft_wave(input logic [4:0] pos);
    logic [7:0] v;
    case (pos)
      5'd0:  v = 8'd0;   5'd1:  v = 8'd0;   5'd2:  v = 8'd2;   5'd3:  v = 8'd5;
      5'd4:  v = 8'd10;  5'd5:  v = 8'd20;  5'd6:  v = 8'd40;  5'd7:  v = 8'd80;
      5'd8:  v = 8'd120; 5'd9:  v = 8'd160; 5'd10: v = 8'd180; 5'd11: v = 8'd160;
      5'd12: v = 8'd140; 5'd13: v = 8'd110; 5'd14: v = 8'd80;  5'd15: v = 8'd50;
      5'd16: v = 8'd30;  5'd17: v = 8'd15;  5'd18: v = 8'd8;   5'd19: v = 8'd3;
      5'd20: v = 8'd1;   5'd21: v = 8'd0;   5'd22: v = 8'd0;   5'd23: v = 8'd0;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Soft-wave channel per mode
  function automatic chan_t mode_soft(input logic [3:0] m);
    chan_t c;
    case (m) inside
      4'd0, 4'd3, 4'd6: c = CH_GREEN;
      4'd1, 4'd4, 4'd7: c = CH_RED;
      default:          c = CH_BLUE;
    endcase
    return c;
  endfunction

  // Hard-wave channel per mode
  function automatic chan_t mode_hard(input logic [3:0] m);
    chan_t c;
    case (m) inside
      4'd3, 4'd5: c = CH_RED;
      4'd4, 4'd6: c = CH_BLUE;
      4'd7, 4'd8: c = CH_GREEN;
      default:    c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/bmwlp_if.sv]
// Valid/ready channel interfaces for requests and results.
// No dependencies; the result fields mirror the result record in bmwlp_pkg.
interface bmwlp_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       pin_released;
  logic [5:0] cell_address;
  logic [7:0] cell_value;
  logic [6:0] pixel_index;

  modport source (output valid, command, pin_released, cell_address, cell_value,
                  pixel_index, input ready);
  modport sink (input valid, command, pin_released, cell_address, cell_value,
                pixel_index, output ready);
endinterface

interface bmwlp_rsp_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [5:0] store_address;
  logic [7:0] store_data;
  logic       last;

  modport source (output valid, kind, red, green, blue, store_address, store_data,
                  last, input ready);
  modport sink (input valid, kind, red, green, blue, store_address, store_data,
                last, output ready);
endinterface

[hw/rtl/button_mode_wave_led_pattern_top.sv]
// Button mode selector and wave pattern source, top level.
// Each result beat is written into a four-entry result queue as its request is taken.
// Throughput: one request per cycle while two queue slots are free (request ready
// only then); a long press yields two beats, drained one per cycle while rsp.ready.
// Reset (rst, synchronous): state and queue cleared, press thresholds to 50 and 3.
// Depends on bmwlp_pkg and bmwlp_if.
module button_mode_wave_led_pattern_top
  import bmwlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  bmwlp_req_if.sink          req,
  bmwlp_rsp_if.source        rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Configuration
  logic [7:0] long_press_ticks;
  logic [7:0] short_press_ticks;

  // Block state
  logic [7:0] press_ticks, press_ticks_next;
  logic [3:0] mode_number, mode_number_next;
  logic [5:0] ring_position, ring_position_next;
  logic [3:0] preview_left, preview_left_next;
  logic [3:0] frame_mode, frame_mode_next;
  logic [4:0] wave_phase, wave_phase_next;
  logic       frame_begun, frame_begun_next;

  // Result queue
  result_t             queue [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  result_t             res0, res1;
  logic [1:0]          push_n;
  logic                accept, pop;

  // Pixel path
  logic [7:0]  phase_sum;
  logic [24:0] recip_prod;
  logic [7:0]  quot;
  logic [7:0]  rem_raw;
  logic [7:0]  rem_fix;
  logic [4:0]  pos;
  logic [3:0]  pix_mode;
  logic [7:0]  soft_val, hard_val;
  chan_t       soft_ch, hard_ch;
  logic [5:0]  ring_inc;

  // APB
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr)
      ADDR_LONG_PRESS:  prdata = {24'd0, long_press_ticks};
      ADDR_SHORT_PRESS: prdata = {24'd0, short_press_ticks};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks  <= LONG_PRESS_RESET;
      short_press_ticks <= SHORT_PRESS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == ADDR_LONG_PRESS)  long_press_ticks  <= pwdata[7:0];
      if (paddr == ADDR_SHORT_PRESS) short_press_ticks <= pwdata[7:0];
    end
  end

  // Handshake
  assign req.ready = (count <= QCNT_W'(QDEPTH - 2));
  assign accept    = req.valid && req.ready;
  assign rsp.valid = (count != '0);
  assign pop       = rsp.valid && rsp.ready;

  assign rsp.kind          = queue[rd_ptr].kind;
  assign rsp.red           = queue[rd_ptr].red;
  assign rsp.green         = queue[rd_ptr].green;
  assign rsp.blue          = queue[rd_ptr].blue;
  assign rsp.store_address = queue[rd_ptr].store_address;
  assign rsp.store_data    = queue[rd_ptr].store_data;
  assign rsp.last          = queue[rd_ptr].last;

  // Table position: (pixel_index + wave_phase) mod WAVE_STEPS by reciprocal
  always_comb begin
    phase_sum  = {1'b0, req.pixel_index} + {3'd0, wave_phase};
    recip_prod = 25'(phase_sum) * 25'(WAVE_RECIP);
    quot       = recip_prod[RECIP_SHIFT +: 8];
    rem_raw    = phase_sum - 8'(quot * 8'(WAVE_STEPS));
    rem_fix    = (rem_raw >= 8'(WAVE_STEPS)) ? rem_raw - 8'(WAVE_STEPS) : rem_raw;
    pos        = rem_fix[4:0];
    pix_mode   = (frame_mode < 4'(MODE_TOTAL)) ? frame_mode : 4'd0;
    soft_ch    = mode_soft(pix_mode);
    hard_ch    = mode_hard(pix_mode);
    soft_val   = (rem_fix < 8'(TABLE_LEN)) ? soft_wave(pos) : 8'd0;
    hard_val   = (rem_fix < 8'(TABLE_LEN)) ? hard_wave(pos) : 8'd0;
    ring_inc   = (ring_position == 6'(SAVE_CELLS - 1)) ? 6'd0 : ring_position + 6'd1;
  end

  // Command decode and next state
  always_comb begin
    press_ticks_next   = press_ticks;
    mode_number_next   = mode_number;
    ring_position_next = ring_position;
    preview_left_next  = preview_left;
    frame_mode_next    = frame_mode;
    wave_phase_next    = wave_phase;
    frame_begun_next   = frame_begun;
    res0               = '0;
    res1               = '0;
    push_n             = 2'd0;

    if (accept) begin
      unique case (req.command)
        CMD_TICK: begin
          if (press_ticks != TICK_MAX) press_ticks_next = press_ticks + 8'd1;
        end
        CMD_PIN: begin
          if (req.pin_released) begin
            if (press_ticks > long_press_ticks) begin
              // erase the old cell, then save the mode in the next one
              ring_position_next  = ring_inc;
              res0.kind           = KIND_STORE;
              res0.store_address  = ring_position;
              res0.store_data     = EMPTY_CELL;
              res1.kind           = KIND_STORE;
              res1.store_address  = ring_inc;
              res1.store_data     = {4'd0, mode_number};
              res1.last           = 1'b1;
              preview_left_next   = 4'(MODE_TOTAL);
              push_n              = 2'd2;
            end else if (press_ticks > short_press_ticks) begin
              mode_number_next = (mode_number >= 4'(MODE_TOTAL - 1)) ? 4'd0
                                                                      : mode_number + 4'd1;
            end
          end
          press_ticks_next = 8'd0;
        end
        CMD_RESTORE: begin
          if (req.cell_value != EMPTY_CELL) begin
            ring_position_next = req.cell_address;
            mode_number_next   = (req.cell_value >= 8'(MODE_TOTAL)) ? 4'd0
                                                                    : req.cell_value[3:0];
          end
        end
        CMD_FRAME: begin
          // advance the phase past the previous frame, if there was one
          if (frame_begun) begin
            wave_phase_next = (wave_phase >= 5'(WAVE_STEPS - 1)) ? 5'd0 : wave_phase + 5'd1;
          end
          frame_begun_next = 1'b1;
          if (preview_left != 4'd0) begin
            preview_left_next = preview_left - 4'd1;
            frame_mode_next   = preview_left - 4'd1;
          end else begin
            frame_mode_next = mode_number;
          end
        end
        CMD_PIXEL: begin
          res0.kind = KIND_PIXEL;
          case (soft_ch)
            CH_RED:   res0.red   = soft_val;
            CH_GREEN: res0.green = soft_val;
            CH_BLUE:  res0.blue  = soft_val;
            default:  ;
          endcase
          case (hard_ch)
            CH_RED:   res0.red   = hard_val;
            CH_GREEN: res0.green = hard_val;
            CH_BLUE:  res0.blue  = hard_val;
            default:  ;
          endcase
          res0.last = 1'b1;
          push_n    = 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks   <= '0;
      mode_number   <= '0;
      ring_position <= '0;
      preview_left  <= '0;
      frame_mode    <= '0;
      wave_phase    <= '0;
      frame_begun   <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      press_ticks   <= press_ticks_next;
      mode_number   <= mode_number_next;
      ring_position <= ring_position_next;
      preview_left  <= preview_left_next;
      frame_mode    <= frame_mode_next;
      wave_phase    <= wave_phase_next;
      frame_begun   <= frame_begun_next;
      wr_ptr        <= wr_ptr + QPTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count         <= count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  // Queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue[wr_ptr] <= res0;
    if (push_n == 2'd2) queue[wr_ptr + QPTR_W'(1)] <= res1;
  end

endmodule

[tb/button_mode_wave_led_pattern_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for button_mode_wave_led_pattern_top: press timing, save ring,
// restore, frame preview and wave pixel lookups, predicted in-bench and checked per beat.
// Depends on bmwlp_pkg, bmwlp_if and the top level RTL.
module button_mode_wave_led_pattern_top_tb;
  import bmwlp_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int DRAIN_CYCLES    = 4;
  localparam int PHASE_ITEMS     = 110;
  localparam logic [3:0] LAST_MODE = 4'(MODE_TOTAL - 1);
  localparam logic [5:0] LAST_CELL = 6'(SAVE_CELLS - 1);
  localparam logic [4:0] LAST_STEP = 5'(WAVE_STEPS - 1);

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  bmwlp_req_if req_if ();
  bmwlp_rsp_if rsp_if ();

  button_mode_wave_led_pattern_top dut (
    .clk(clk), .rst(rst), .req(req_if), .rsp(rsp_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Wave curves and the channel each mode drives from them
  logic [7:0] bright_curve [TABLE_LEN] = '{
    8'd0, 8'd5, 8'd15, 8'd30, 8'd60, 8'd100, 8'd150, 8'd200,
    8'd240, 8'd255, 8'd255, 8'd240, 8'd220, 8'd200, 8'd170, 8'd140,
    8'd110, 8'd80, 8'd55, 8'd35, 8'd20, 8'd10, 8'd5, 8'd0};
  logic [7:0] dim_curve [TABLE_LEN] = '{
    8'd0, 8'd0, 8'd2, 8'd5, 8'd10, 8'd20, 8'd40, 8'd80,
    8'd120, 8'd160, 8'd180, 8'd160, 8'd140, 8'd110, 8'd80, 8'd50,
    8'd30, 8'd15, 8'd8, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0};
  chan_t dim_channel [MODE_TOTAL] = '{CH_GREEN, CH_RED, CH_BLUE, CH_GREEN, CH_RED,
                                      CH_BLUE, CH_GREEN, CH_RED, CH_BLUE};
  chan_t bright_channel [MODE_TOTAL] = '{CH_NONE, CH_NONE, CH_NONE, CH_RED, CH_BLUE,
                                         CH_RED, CH_BLUE, CH_GREEN, CH_GREEN};

  // Shadow of the block's state and thresholds
  logic [7:0] long_thresh  = LONG_PRESS_RESET;
  logic [7:0] short_thresh = SHORT_PRESS_RESET;
  logic [7:0] press_count  = '0;
  logic [3:0] mode_sel     = '0;
  logic [5:0] ring_pos     = '0;
  logic [3:0] preview_left = '0;
  logic [3:0] frame_sel    = '0;
  logic [4:0] phase        = '0;
  logic       frame_seen   = 1'b0;

  result_t due_beats [$];
  int mismatches   = 0;
  int quiet_cycles = 0;
  int hold_off_req = 0;
  int burst_left   = 0;
  int live_items   = 0;

  task automatic predict_command(input logic [2:0] cmd, input logic rel,
                                 input logic [5:0] addr, input logic [7:0] val,
                                 input logic [6:0] pix);
    result_t beat;
    logic [4:0] pos;
    logic [3:0] m;
    logic [7:0] col [4];
    beat = '0;
    case (cmd)
      CMD_TICK: begin
        if (press_count != TICK_MAX) press_count++;
      end
      CMD_PIN: begin
        if (rel) begin
          if (press_count > long_thresh) begin
            // erase the old cell, then write the mode to the next one
            beat.kind = KIND_STORE;
            beat.store_address = ring_pos;
            beat.store_data = EMPTY_CELL;
            due_beats.push_back(beat);
            ring_pos = (ring_pos == LAST_CELL) ? '0 : ring_pos + 6'd1;
            beat.store_address = ring_pos;
            beat.store_data = {4'd0, mode_sel};
            beat.last = 1'b1;
            due_beats.push_back(beat);
            preview_left = 4'(MODE_TOTAL);
          end else if (press_count > short_thresh) begin
            mode_sel = (mode_sel == LAST_MODE) ? '0 : mode_sel + 4'd1;
          end
        end
        press_count = '0;
      end
      CMD_RESTORE: begin
        if (val != EMPTY_CELL) begin
          ring_pos = addr;
          mode_sel = (val > 8'(LAST_MODE)) ? '0 : val[3:0];
        end
      end
      CMD_FRAME: begin
        // the first frame after reset keeps the phase where it is
        if (frame_seen) phase = (phase == LAST_STEP) ? '0 : phase + 5'd1;
        frame_seen = 1'b1;
        if (preview_left != '0) begin
          preview_left--;
          frame_sel = preview_left;
        end else begin
          frame_sel = mode_sel;
        end
      end
      CMD_PIXEL: begin
        pos = 5'((32'(pix) + 32'(phase)) % WAVE_STEPS);
        m = (frame_sel > LAST_MODE) ? '0 : frame_sel;
        col = '{default: 8'd0};
        col[dim_channel[m]] = dim_curve[pos];
        if (bright_channel[m] != CH_NONE) col[bright_channel[m]] = bright_curve[pos];
        beat.kind = KIND_PIXEL;
        beat.red = col[CH_RED];
        beat.green = col[CH_GREEN];
        beat.blue = col[CH_BLUE];
        beat.last = 1'b1;
        due_beats.push_back(beat);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string label, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result_beat();
    result_t want;
    if (due_beats.size() == 0) begin
      $display("%0t: result beat with nothing expected, expected none, actual kind %0d",
               $time, rsp_if.kind);
      mismatches++;
    end else begin
      want = due_beats.pop_front();
      compare_field("kind", want.kind, rsp_if.kind);
      compare_field("red", want.red, rsp_if.red);
      compare_field("green", want.green, rsp_if.green);
      compare_field("blue", want.blue, rsp_if.blue);
      compare_field("store_address", want.store_address, rsp_if.store_address);
      compare_field("store_data", want.store_data, rsp_if.store_data);
      compare_field("last", want.last, rsp_if.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) check_result_beat();
      if (req_if.valid && req_if.ready)
        predict_command(req_if.command, req_if.pin_released, req_if.cell_address,
                        req_if.cell_value, req_if.pixel_index);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result sink: stall pattern of its own, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    int pattern_left;
    int ready_odds;
    int hold_off_taken;
    hold_left = 0;
    pattern_left = 0;
    ready_odds = 4;
    hold_off_taken = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req != hold_off_taken) begin
        hold_off_taken = hold_off_req;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(4, 40);
        ready_odds = $urandom_range(1, 4);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(1, 4) <= 32'(ready_odds));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(input logic [2:0] cmd, input logic rel, input logic [5:0] addr,
                           input logic [7:0] val, input logic [6:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.pin_released <= rel;
    req_if.cell_address <= addr;
    req_if.cell_value <= val;
    req_if.pixel_index <= pix;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    if (cmd <= CMD_PIXEL && !(cmd == CMD_RESTORE && val == EMPTY_CELL)) live_items++;
  endtask

  task automatic send_noisy(input logic [2:0] cmd);
    send_item(cmd, 1'($urandom), 6'($urandom), 8'($urandom), 7'($urandom));
  endtask

  task automatic send_pixel(input logic [6:0] pix);
    send_item(CMD_PIXEL, 1'($urandom), 6'($urandom), 8'($urandom), pix);
  endtask

  task automatic send_restore(input logic [5:0] addr, input logic [7:0] val);
    send_item(CMD_RESTORE, 1'($urandom), addr, val, 7'($urandom));
  endtask

  task automatic press_button(input int ticks, input logic rel);
    send_item(CMD_PIN, 1'b0, 6'($urandom), 8'($urandom), 7'($urandom));
    repeat (ticks) send_noisy(CMD_TICK);
    send_item(CMD_PIN, rel, 6'($urandom), 8'($urandom), 7'($urandom));
  endtask

  // Drop valid and hold until every due beat has arrived
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (due_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_thresholds(input logic [7:0] long_ticks, input logic [7:0] short_ticks);
    write_register(ADDR_LONG_PRESS, {24'd0, long_ticks});
    long_thresh = long_ticks;
    write_register(ADDR_SHORT_PRESS, {24'd0, short_ticks});
    short_thresh = short_ticks;
  endtask

  task automatic test_directed();
    send_item(CMD_PIXEL, 1'b1, 6'd63, 8'hFF, 7'd0);
    send_item(CMD_PIXEL, 1'b0, 6'd0, 8'd0, 7'd127);
    send_noisy(CMD_FRAME);
    send_noisy(CMD_FRAME);
    send_pixel(7'd23);
    send_restore(6'd12, EMPTY_CELL);
    send_restore(6'd0, 8'd9);
    send_restore(6'd5, 8'd0);
    send_restore(6'd63, 8'd8);
    send_noisy(CMD_FRAME);
    send_pixel(7'd5);
    send_item(3'd5, 1'b1, 6'd63, 8'hFF, 7'd127);
    send_item(3'd6, 1'b1, 6'd63, 8'hFF, 7'd127);
    send_item(3'd7, 1'b1, 6'd63, 8'hFF, 7'd127);
    // short press steps mode 8 round to 0; a bare release then does nothing
    press_button(4, 1'b1);
    send_item(CMD_PIN, 1'b1, 6'd0, 8'd0, 7'd0);
    send_noisy(CMD_FRAME);
    send_pixel(7'd100);
    wait_drained();
  endtask

  task automatic test_save_preview();
    int i;
    write_thresholds(8'd254, 8'd255);
    send_restore(6'd63, 8'd6);
    // saturated count saves from the last cell and wraps the ring
    press_button(260, 1'b1);
    for (i = 0; i < 11; i++) begin
      send_noisy(CMD_FRAME);
      send_pixel(7'($urandom));
      send_pixel(7'($urandom));
    end
    wait_drained();
    write_thresholds(8'd255, 8'd254);
    press_button(256, 1'b1);
    send_noisy(CMD_FRAME);
    send_pixel(7'($urandom));
    wait_drained();
  endtask

  task automatic test_backpressure();
    int i;
    write_thresholds(8'd2, 8'd1);
    @(posedge clk);
    hold_off_req++;
    @(negedge clk);
    burst_left = 200;
    send_noisy(CMD_FRAME);
    for (i = 0; i < 30; i++) send_pixel(7'($urandom));
    press_button(4, 1'b1);
    for (i = 0; i < 10; i++) send_pixel(7'($urandom));
    wait_drained();
    send_noisy(CMD_FRAME);
    press_button(3, 1'b1);
    send_pixel(7'($urandom));
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [7:0] long_set [6]  = '{8'd6, 8'd0, 8'd255, 8'd3, 8'd12, LONG_PRESS_RESET};
    logic [7:0] short_set [6] = '{8'd2, 8'd0, 8'd4, 8'd255, 8'd1, SHORT_PRESS_RESET};
    int p;
    int i;
    int n;
    int ticks;
    int phase_start;
    logic [7:0] val;
    for (p = 0; p < 6; p++) begin
      wait_drained();
      write_thresholds(long_set[p], short_set[p]);
      phase_start = live_items;
      while (live_items - phase_start < PHASE_ITEMS) begin
        n = $urandom_range(0, 99);
        if (n < 25) begin
          case ($urandom_range(0, 4))
            0: ticks = int'(short_thresh);
            1: ticks = int'(short_thresh) + 1;
            2: ticks = int'(long_thresh);
            3: ticks = int'(long_thresh) + 1;
            default: ticks = $urandom_range(0, 8);
          endcase
          if (ticks > 60) ticks = $urandom_range(0, 60);
          press_button(ticks, ($urandom_range(0, 7) != 0));
        end else if (n < 55) begin
          send_noisy(CMD_FRAME);
          repeat ($urandom_range(1, 8)) send_pixel(7'($urandom));
        end else if (n < 65) begin
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3)) inside
              0: val = EMPTY_CELL;
              1, 2: val = 8'($urandom_range(0, 8));
              default: val = 8'($urandom);
            endcase
            send_restore(6'($urandom), val);
          end
        end else if (n < 80) begin
          repeat ($urandom_range(1, 4)) send_noisy(3'($urandom));
        end else begin
          repeat ($urandom_range(1, 6)) send_pixel(7'($urandom));
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.command = CMD_TICK;
    req_if.pin_released = 1'b0;
    req_if.cell_address = '0;
    req_if.cell_value = '0;
    req_if.pixel_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_save_preview();
    test_backpressure();
    test_random_phases();

    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
